FILE: hdl/free_block_fit_selector_macros.svh
// ---------------------------------------------------------------------------
// Free block fit selector assertion macros
// Shared concurrent assertion wrappers, clocked on clk; FBFS_ASSERT is disabled by rst.
// ---------------------------------------------------------------------------
`ifndef FREE_BLOCK_FIT_SELECTOR_MACROS_SVH
`define FREE_BLOCK_FIT_SELECTOR_MACROS_SVH

// checked only out of reset
`define FBFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define FBFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/fbfs_pkg.sv
// ---------------------------------------------------------------------------
// Free block fit selector package
// Defaults, mode codes and the types shared by the sequencer and scan unit.
// ---------------------------------------------------------------------------
package fbfs_pkg;

  // default geometry
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int SIZE_BITS_DEF   = 32;

  // scan index width follows the table_count field
  localparam int IDX_BITS = 7;

  typedef logic [IDX_BITS-1:0] idx_t;

  // mode codes
  localparam logic [2:0] MODE_WRITE = 3'd0;
  localparam logic [2:0] MODE_FIRST = 3'd1;
  localparam logic [2:0] MODE_NEXT  = 3'd2;
  localparam logic [2:0] MODE_BEST  = 3'd3;
  localparam logic [2:0] MODE_WORST = 3'd4;

  // sequencer to scan unit
  typedef struct packed {
    logic clear;  // any accepted item: start of a query or a write
    logic valid;  // read data valid this cycle
    idx_t idx;    // index of the read data
  } scan_ctl_t;

  // scan unit to sequencer
  typedef struct packed {
    logic hit;       // some entry fits
    idx_t hit_idx;   // first fitting entry in scan order
    idx_t best_idx;  // smallest fitting entry
    idx_t max_idx;   // largest entry
  } scan_stat_t;

endpackage

FILE: hdl/free_block_fit_selector.sv
// ---------------------------------------------------------------------------
// Free block fit selector
// Block size table with first, next, best and worst fit queries.
// ---------------------------------------------------------------------------
// Channel  Dir  Fields (low bit first)
// s_       in   tuser: mode; tdata: entry_index, entry_size, request_size,
//                      table_count, last_index
// m_       out  tdata: chosen_index, fits
//
// A write item is written to the table at accept. A query scans n entries, n
// being the saturated table count, with the scan unit seeing one RAM entry per
// cycle; next fit first works out the start index remainder (last mod n).
// A query with zero count or an unused mode skips the scan.
// Input is taken only while the sequencer is idle; a result waits in the
// output register while m_tready is low. Reset is synchronous; the table
// is not cleared and has no reset contents.
// ---------------------------------------------------------------------------
`include "free_block_fit_selector_macros.svh"

module free_block_fit_selector
  import fbfs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // entry_index, entry_size, request_size,
                                 // table_count, last_index, zero fill
  input  logic [2:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // chosen_index, fits, zero fill
);

  localparam int   ADDR_W = $clog2(TABLE_DEPTH);
  localparam idx_t N_MAX  = (TABLE_DEPTH > 127) ? 7'd127 : IDX_BITS'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // input fields
  logic [2:0]  in_mode;
  logic [5:0]  in_eidx;
  logic [31:0] in_esize;
  logic [31:0] in_req;
  idx_t        in_count;
  logic [5:0]  in_last;

  assign in_mode  = s_tuser;
  assign in_eidx  = s_tdata[5:0];
  assign in_esize = s_tdata[37:6];
  assign in_req   = s_tdata[69:38];
  assign in_count = s_tdata[76:70];
  assign in_last  = s_tdata[82:77];

  logic [1:0]           state;
  logic [2:0]           mode;
  logic                 zres;
  logic [SIZE_BITS-1:0] req;
  idx_t                 n;
  logic [5:0]           last;
  logic [2:0]           bcnt;
  idx_t                 rem;
  idx_t                 k;
  idx_t                 icnt;
  logic                 rd_vld;
  idx_t                 rd_idx;
  logic [5:0]           out_idx;
  logic                 out_fit;

  logic                 accept;
  logic                 is_query;
  idx_t                 n_in;
  logic [7:0]           rem_try;
  idx_t                 rem_next;
  logic [7:0]           fb_try;
  idx_t                 fb_idx;
  idx_t                 pick;
  logic                 ram_we;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic                 out_free;
  scan_ctl_t            sctl;
  scan_stat_t           sstat;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // saturated count and query check
  assign n_in     = (in_count > N_MAX) ? N_MAX : in_count;
  assign is_query = ((in_mode == MODE_FIRST) || (in_mode == MODE_NEXT) ||
                     (in_mode == MODE_BEST) || (in_mode == MODE_WORST)) &&
                    (n_in != '0);

  // table writes happen at accept
  assign ram_we = accept && (in_mode == MODE_WRITE) &&
                  (int'(in_eidx) < TABLE_DEPTH);

  fbfs_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_eidx)),
    .wdata (SIZE_BITS'(in_esize)),
    .raddr (ADDR_W'(k)),
    .rdata (ram_rdata)
  );

  // remainder step: last mod n, one bit per cycle
  assign rem_try  = {rem, last[bcnt]};
  assign rem_next = (rem_try >= {1'b0, n}) ? IDX_BITS'(rem_try - {1'b0, n})
                                           : rem_try[IDX_BITS-1:0];

  // next fit fallback: (2 * last) mod n from last mod n
  assign fb_try = {rem, 1'b0};
  assign fb_idx = (fb_try >= {1'b0, n}) ? IDX_BITS'(fb_try - {1'b0, n})
                                        : fb_try[IDX_BITS-1:0];

  // scan unit
  assign sctl.clear = accept;
  assign sctl.valid = rd_vld;
  assign sctl.idx   = rd_idx;

  fbfs_scan_unit #(
    .SIZE_BITS (SIZE_BITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sctl),
    .req  (req),
    .data (ram_rdata),
    .stat (sstat)
  );

  // policy select
  always_comb begin
    case (mode)
      MODE_FIRST: pick = sstat.hit ? sstat.hit_idx : '0;
      MODE_NEXT:  pick = sstat.hit ? sstat.hit_idx : fb_idx;
      MODE_BEST:  pick = sstat.hit ? sstat.best_idx : sstat.max_idx;
      MODE_WORST: pick = sstat.max_idx;
      default:    pick = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!is_query) begin
              state <= ST_FIN;
            end else if (in_mode == MODE_NEXT) begin
              state <= ST_MOD;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_MOD: begin
          if (bcnt == 3'd0) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (icnt != n) begin
            rd_vld <= 1'b1;
          end else if (!rd_vld) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // query registers, remainder and scan counters
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          mode <= in_mode;
          zres <= !is_query;
          req  <= SIZE_BITS'(in_req);
          n    <= n_in;
          last <= in_last;
          bcnt <= 3'd5;
          rem  <= '0;
          k    <= '0;
          icnt <= '0;
        end
      end
      ST_MOD: begin
        rem  <= rem_next;
        bcnt <= bcnt - 3'd1;
        if (bcnt == 3'd0) begin
          k <= rem_next;
        end
      end
      ST_SCAN: begin
        if (icnt != n) begin
          rd_idx <= k;
          icnt   <= icnt + 7'd1;
          k      <= (k + 7'd1 == n) ? '0 : k + 7'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_idx <= zres ? 6'd0 : pick[5:0];
      out_fit <= zres ? 1'b0 : sstat.hit;
    end
  end

  assign m_tdata = {1'b0, out_fit, out_idx};

  // checks
  `FBFS_ASSERT(a_icnt_bound, (state == ST_SCAN) |-> (icnt <= n), "scan ran past count")
  `FBFS_ASSERT(a_k_bound, (state == ST_SCAN && icnt != n) |-> (k < n), "scan index out of range")
  `FBFS_ASSERT(a_rd_bound, rd_vld |-> (rd_idx < n), "read tag out of range")
  `FBFS_ASSERT(a_rem_bound, (state == ST_SCAN) |-> (rem < n), "remainder not below count")
  `FBFS_ASSERT_ALWAYS(a_load, (!rst && state == ST_FIN && out_free) |=> m_tvalid, "result not loaded")

endmodule

FILE: hdl/fbfs_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module fbfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/fbfs_scan_unit.sv
// ---------------------------------------------------------------------------
// Fit scan unit
// Compares one table entry per cycle against the request and running picks.
// ---------------------------------------------------------------------------
module fbfs_scan_unit
  import fbfs_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scan_ctl_t            ctl,
  input  logic [SIZE_BITS-1:0] req,
  input  logic [SIZE_BITS-1:0] data,
  output scan_stat_t           stat
);

  logic                 hit;
  idx_t                 hit_idx;
  idx_t                 best_idx;
  logic [SIZE_BITS-1:0] best_val;
  logic                 max_seen;
  idx_t                 max_idx;
  logic [SIZE_BITS-1:0] max_val;

  logic fit_now;
  logic best_upd;
  logic max_upd;

  // shared compares for the current entry
  assign fit_now  = (data >= req);
  assign best_upd = fit_now && (!hit || (data < best_val));
  assign max_upd  = !max_seen || (data > max_val);

  // running picks, earliest entry in scan order wins ties
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hit      <= 1'b0;
      max_seen <= 1'b0;
    end else if (ctl.valid) begin
      if (fit_now) begin
        hit <= 1'b1;
      end
      max_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      if (fit_now && !hit) begin
        hit_idx <= ctl.idx;
      end
      if (best_upd) begin
        best_idx <= ctl.idx;
        best_val <= data;
      end
      if (max_upd) begin
        max_idx <= ctl.idx;
        max_val <= data;
      end
    end
  end

  assign stat.hit      = hit;
  assign stat.hit_idx  = hit_idx;
  assign stat.best_idx = best_idx;
  assign stat.max_idx  = max_idx;

endmodule
